[rtl/core/fr_pkg.sv]
// Shared types, widths and state encoding for the fraction reducer.
package fr_pkg;

    localparam int FR_W   = 32;
    localparam int FR_KW  = $clog2(FR_W);

    typedef logic [FR_W-1:0]  t_fr_word;
    typedef logic [FR_KW-1:0] t_fr_shift;

    // Input transaction: two ratios to be multiplied together.
    typedef struct packed {
        t_fr_word bus_rate_num;
        t_fr_word bus_rate_den;
        t_fr_word decrementer_ratio_num;
        t_fr_word decrementer_ratio_den;
    } t_fr_in;

    // Result transaction: the product ratio in lowest terms, or unreduced when the denominator is zero.
    typedef struct packed {
        t_fr_word reduced_num;
        t_fr_word reduced_den;
    } t_fr_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_NUM,
        ST_MUL_DEN,
        ST_GCD_INIT,
        ST_GCD,
        ST_DIV_NUM,
        ST_DIV_SWAP,
        ST_DIV_DEN,
        ST_DIV_END,
        ST_DONE
    } t_fr_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic mul_num;
        logic mul_den;
        logic gcd_init;
        logic gcd_step;
        logic div_load_num;
        logic div_load_den;
        logic div_step;
        logic div_store_num;
        logic div_store_den;
        logic load_out;
    } t_fr_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic den_zero;
        logic gcd_done;
        logic div_last;
    } t_fr_sts;

endpackage

[rtl/core/fr_stream_if.sv]
// Valid/ready stream interface carrying one payload per transaction.
interface fr_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/fraction_reducer.sv]
// Top level of the fraction reducer: product of two ratios in lowest terms.
//
// Usage:
//   i_in  (sink) takes one transaction holding two ratios, num/den each 32 bits.
//   o_res (source) returns num = low word of the numerator product and
//   den = low word of the denominator product, both divided by their gcd.
//   A zero denominator returns both products unchanged; a zero numerator
//   with a nonzero denominator returns 0/1.
// Sequence: form both products and seed the gcd, then run the binary gcd
//   loop until u reaches zero and latch the divisor, then run two 32-step
//   restoring divisions on one shared divider and load the result register.
//   A zero denominator skips gcd and division.
// Throughput: one transaction at a time; i_in.ready is high only while idle,
//   from the cycle after the result register loads. A new transaction is
//   accepted while the previous result still waits in the output register.
// Reset: synchronous, active low; clears the controller and result valid.
// Stall: a result held by o_res.ready low stays stable; a finished item
//   waits in its final state until the output register frees up.
module fraction_reducer
    import fr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    fr_stream_if.sink   i_in,
    fr_stream_if.source o_res
);

    t_fr_cmd w_cmd;
    t_fr_sts w_sts;

    fr_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (w_cmd)
    );

    fr_datapath u_dp (
        .i_clk     (i_clk),
        .i_payload (i_in.payload),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .o_payload (o_res.payload)
    );

endmodule

[rtl/core/fr_datapath.sv]
// Datapath: shared multiplier, binary gcd unit, shared restoring divider, output register.
module fr_datapath
    import fr_pkg::*;
(
    input  logic    i_clk,
    input  t_fr_in  i_payload,
    input  t_fr_cmd i_cmd,
    output t_fr_sts o_sts,
    output t_fr_out o_payload
);

    t_fr_word  r_a, r_b, r_c, r_d;
    t_fr_word  r_res_num, r_res_den;
    t_fr_word  r_u, r_v, r_g;
    t_fr_shift r_k;
    t_fr_word  r_x, r_rem;
    t_fr_shift r_cnt;
    t_fr_out   r_out;

    t_fr_word  w_mul_x, w_mul_y, w_prod;
    t_fr_word  n_u, n_v;
    t_fr_shift n_k;
    logic [FR_W:0] w_rem_sh, w_diff;
    logic      w_qbit;
    t_fr_word  n_rem, n_x;

    // Share one multiplier between the two products; keep the low word
    always_comb begin
        w_mul_x = i_cmd.mul_den ? r_b : r_a;
        w_mul_y = i_cmd.mul_den ? r_d : r_c;
        w_prod  = w_mul_x * w_mul_y;
    end

    // One binary gcd step: strip common twos, strip lone twos, else subtract
    always_comb begin
        n_u = r_u;
        n_v = r_v;
        n_k = r_k;
        if (!r_u[0] && !r_v[0]) begin
            n_u = r_u >> 1;
            n_v = r_v >> 1;
            n_k = r_k + 1'b1;
        end else if (!r_u[0]) begin
            n_u = r_u >> 1;
        end else if (!r_v[0]) begin
            n_v = r_v >> 1;
        end else if (r_u >= r_v) begin
            n_u = r_u - r_v;
        end else begin
            n_v = r_v - r_u;
        end
    end

    // One restoring division step; quotient bits shift into the dividend register
    always_comb begin
        w_rem_sh = {r_rem, r_x[FR_W-1]};
        w_diff   = w_rem_sh - {1'b0, r_g};
        w_qbit   = !w_diff[FR_W];
        n_rem    = w_qbit ? w_diff[FR_W-1:0] : w_rem_sh[FR_W-1:0];
        n_x      = {r_x[FR_W-2:0], w_qbit};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_a <= i_payload.bus_rate_num;
            r_b <= i_payload.bus_rate_den;
            r_c <= i_payload.decrementer_ratio_num;
            r_d <= i_payload.decrementer_ratio_den;
        end
        if (i_cmd.mul_num) begin
            r_res_num <= w_prod;
        end
        if (i_cmd.mul_den) begin
            r_res_den <= w_prod;
        end
        if (i_cmd.gcd_init) begin
            r_u <= r_res_num;
            r_v <= r_res_den;
            r_k <= '0;
        end
        // Latch the divisor once u has reached zero, else advance
        if (i_cmd.gcd_step) begin
            if (r_u == '0) begin
                r_g <= r_v << r_k;
            end else begin
                r_u <= n_u;
                r_v <= n_v;
                r_k <= n_k;
            end
        end
        if (i_cmd.div_load_num || i_cmd.div_load_den) begin
            r_x   <= i_cmd.div_load_num ? r_res_num : r_res_den;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_x   <= n_x;
            r_rem <= n_rem;
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.div_store_num) begin
            r_res_num <= r_x;
        end
        if (i_cmd.div_store_den) begin
            r_res_den <= r_x;
        end
        if (i_cmd.load_out) begin
            r_out.reduced_num <= r_res_num;
            r_out.reduced_den <= r_res_den;
        end
    end

    assign o_sts.den_zero = (r_res_den == '0);
    assign o_sts.gcd_done = (r_u == '0);
    assign o_sts.div_last = (r_cnt == t_fr_shift'(FR_W - 1));
    assign o_payload      = r_out;

endmodule

[rtl/core/fr_controller.sv]
// Controller: sequences multiply, gcd and divide steps and owns the handshakes.
module fr_controller
    import fr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_fr_sts i_sts,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_fr_cmd o_cmd
);

    t_fr_state r_state, n_state;
    logic      r_out_valid, n_out_valid;

    // Hold state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_MUL_NUM;
                end
            end
            ST_MUL_NUM: begin
                o_cmd.mul_num = 1'b1;
                n_state       = ST_MUL_DEN;
            end
            ST_MUL_DEN: begin
                o_cmd.mul_den = 1'b1;
                n_state       = ST_GCD_INIT;
            end
            ST_GCD_INIT: begin
                // A zero denominator passes both products through
                o_cmd.gcd_init = 1'b1;
                n_state        = i_sts.den_zero ? ST_DONE : ST_GCD;
            end
            ST_GCD: begin
                o_cmd.gcd_step = 1'b1;
                if (i_sts.gcd_done) begin
                    o_cmd.div_load_num = 1'b1;
                    n_state            = ST_DIV_NUM;
                end
            end
            ST_DIV_NUM: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_DIV_SWAP;
                end
            end
            ST_DIV_SWAP: begin
                o_cmd.div_store_num = 1'b1;
                o_cmd.div_load_den  = 1'b1;
                n_state             = ST_DIV_DEN;
            end
            ST_DIV_DEN: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_DIV_END;
                end
            end
            ST_DIV_END: begin
                o_cmd.div_store_den = 1'b1;
                n_state             = ST_DONE;
            end
            ST_DONE: begin
                // Wait until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Raise valid on load, drop it once the result transaction completes
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/core/fr_checker.sv]
// Port-level checks for the fraction reducer, bound to the top level.
module fr_checker
    import fr_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_res_valid,
    input logic    i_res_ready,
    input t_fr_out i_res_payload
);

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !i_res_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_payload))
        else $error("stalled result changed");

    // One transaction at a time: input closes after acceptance
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while busy");

    // A zero numerator over a nonzero denominator reduces to 0/1
    a_zero_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_payload.reduced_num == '0)
            && (i_res_payload.reduced_den != '0)
        |-> i_res_payload.reduced_den == t_fr_word'(1))
        else $error("zero numerator not reduced to 0/1");

endmodule

bind fraction_reducer fr_checker u_fr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_payload (o_res.payload)
);

[test/fraction_reducer_tb.sv]
// Self-checking testbench for the fraction reducer: directed table, then random ratios.
module fraction_reducer_tb;
    import fr_pkg::*;

    localparam int NUM_CASES   = 22;
    localparam int NUM_RANDOM  = 730;
    localparam int HOLD_OFF    = 1500;  // long receiver stall, fills the block
    localparam int HOLD_AFTER  = 300;   // transactions accepted before the stall
    localparam int IDLE_LIMIT  = 8000;  // cycles without any transaction
    localparam int DRAIN       = 250;   // settle time after the last result
    localparam int MAX_REPORTS = 10;

    // One directed row: operands, and the result where it is typed in.
    typedef struct packed {
        t_fr_in  operands;
        logic    typed;
        t_fr_out result;
    } t_ratio_case;

    localparam t_ratio_case RATIO_CASES [NUM_CASES] = '{
        // all zero: zero denominator passes 0/0 through
        '{'{32'd0, 32'd0, 32'd0, 32'd0}, 1'b1, '{32'd0, 32'd0}},
        // zero numerator gives 0/1
        '{'{32'd0, 32'd5, 32'd3, 32'd7}, 1'b1, '{32'd0, 32'd1}},
        '{'{32'd3, 32'd1, 32'd0, 32'd5}, 1'b1, '{32'd0, 32'd1}},
        // denominator of one passes through
        '{'{32'd7, 32'd1, 32'd3, 32'd1}, 1'b1, '{32'd21, 32'd1}},
        '{'{32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1}, 1'b1, '{32'hFFFF_FFFF, 32'd1}},
        // all ones: both products truncate to one
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
          '{32'd1, 32'd1}},
        // numerator product overflows to zero
        '{'{32'h0001_0000, 32'd3, 32'h0001_0000, 32'd5}, 1'b1, '{32'd0, 32'd1}},
        // denominator product overflows to zero, pass through
        '{'{32'd6, 32'h0001_0000, 32'd7, 32'h0001_0000}, 1'b1, '{32'd42, 32'd0}},
        // zero denominator with live numerator
        '{'{32'd12, 32'd0, 32'd5, 32'd7}, 1'b1, '{32'd60, 32'd0}},
        '{'{32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{32'd0, 32'd0}},
        // plain reductions
        '{'{32'd6, 32'd4, 32'd1, 32'd1}, 1'b1, '{32'd3, 32'd2}},
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd1}, 1'b1, '{32'd1, 32'd1}},
        '{'{32'd1, 32'hFFFF_FFFF, 32'd1, 32'd1}, 1'b1, '{32'd1, 32'hFFFF_FFFF}},
        '{'{32'h8000_0000, 32'd2, 32'd1, 32'd1}, 1'b1, '{32'h4000_0000, 32'd1}},
        // the rest are left to the predictor
        '{'{32'd33333333, 32'd100000000, 32'd3, 32'd1}, 1'b0, '{32'd0, 32'd0}},
        '{'{32'hDEAD_BEEF, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9}, 1'b0,
          '{32'd0, 32'd0}},
        '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b0,
          '{32'd0, 32'd0}},
        '{'{32'h8000_0000, 32'h4000_0000, 32'd1, 32'd3}, 1'b0, '{32'd0, 32'd0}},
        '{'{32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'd2, 32'd1}, 1'b0, '{32'd0, 32'd0}},
        '{'{32'd1001, 32'd7007, 32'd13, 32'd11}, 1'b0, '{32'd0, 32'd0}},
        '{'{32'd65535, 32'd65537, 32'd65537, 32'd65535}, 1'b0, '{32'd0, 32'd0}},
        '{'{32'd27000000, 32'd33000000, 32'd1, 32'd4}, 1'b0, '{32'd0, 32'd0}}
    };

    logic i_clk;
    logic i_rst_n;

    fr_stream_if #(.t_payload(t_fr_in))  in_if ();
    fr_stream_if #(.t_payload(t_fr_out)) res_if ();

    t_fr_out     pending_ratios[$];
    int unsigned accepted_cnt;
    int unsigned mismatch_cnt;
    int unsigned idle_cycles;
    int unsigned burst_left;

    fraction_reducer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_res   (res_if.source)
    );

    // Free-running clock, period 2
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Product of both ratios, truncated to 32 bits, divided by its gcd
    function automatic t_fr_out reduce_ratio(input t_fr_in op);
        t_fr_word num;
        t_fr_word den;
        t_fr_word x;
        t_fr_word y;
        t_fr_word r;
        t_fr_out  res;
        num = op.bus_rate_num * op.decrementer_ratio_num;
        den = op.bus_rate_den * op.decrementer_ratio_den;
        if (den != '0) begin
            x = num;
            y = den;
            while (y != '0) begin
                r = x % y;
                x = y;
                y = r;
            end
            num = num / x;
            den = den / x;
        end
        res.reduced_num = num;
        res.reduced_den = den;
        return res;
    endfunction

    // Mix of small, power-of-two heavy, near-max and full-range operands
    function automatic t_fr_word rand_operand();
        case ($urandom_range(0, 9))
            0: begin
                return ($urandom_range(0, 2) == 0) ? t_fr_word'(0) : t_fr_word'(1);
            end
            1, 2: begin
                return t_fr_word'($urandom_range(1, 64));
            end
            3, 4: begin
                return t_fr_word'($urandom_range(1, 100000));
            end
            5: begin
                return t_fr_word'($urandom_range(1, 255)) << $urandom_range(0, 31);
            end
            6: begin
                return t_fr_word'($urandom);
            end
            7: begin
                return ~t_fr_word'($urandom_range(0, 15));
            end
            default: begin
                return t_fr_word'($urandom_range(1, 4096)) << $urandom_range(0, 12);
            end
        endcase
    endfunction

    function automatic t_fr_in random_ratio();
        t_fr_in      op;
        int unsigned k;
        op.bus_rate_num          = rand_operand();
        op.bus_rate_den          = rand_operand();
        op.decrementer_ratio_num = rand_operand();
        op.decrementer_ratio_den = rand_operand();
        // share a factor across the bus ratio so the gcd has work to do
        if ($urandom_range(0, 1) == 1) begin
            k = $urandom_range(2, 1000);
            op.bus_rate_num = op.bus_rate_num * k;
            op.bus_rate_den = op.bus_rate_den * k;
        end
        // let one term cancel outright now and then
        if ($urandom_range(0, 4) == 0) begin
            op.decrementer_ratio_num = op.bus_rate_den;
        end
        return op;
    endfunction

    task automatic flag_mismatch(input string detail);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $time, detail);
        end
    endtask

    // Offer one ratio, hold it until accepted, then close or extend the burst
    task automatic offer_ratio(input t_fr_in op, input logic typed, input t_fr_out result);
        in_if.valid   <= 1'b1;
        in_if.payload <= op;
        do @(posedge i_clk); while (!in_if.ready);
        pending_ratios.push_back(typed ? result : reduce_ratio(op));
        accepted_cnt++;
        if (burst_left == 0) begin
            in_if.valid <= 1'b0;
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(20, 250)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 5);
        end else begin
            burst_left--;
        end
    endtask

    // Reset, stimulus and end of run
    initial begin
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        accepted_cnt  = 0;
        mismatch_cnt  = 0;
        burst_left    = 3;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_CASES; i++) begin
            offer_ratio(RATIO_CASES[i].operands, RATIO_CASES[i].typed,
                        RATIO_CASES[i].result);
        end
        for (int i = 0; i < NUM_RANDOM; i++) begin
            offer_ratio(random_ratio(), 1'b0, '0);
        end
        in_if.valid <= 1'b0;

        // drain, then give any stray result time to show up
        while (pending_ratios.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("fraction_reducer test passed");
        end else begin
            $display("fraction_reducer test failed");
        end
        $finish;
    end

    // Result side: change stall pattern after each random span, one long hold-off
    initial begin : receiver
        int unsigned  span;
        int unsigned  mode;
        logic [31:0]  pattern;
        bit           held;
        res_if.ready = 1'b0;
        held         = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!held && accepted_cnt >= HOLD_AFTER) begin
                held = 1'b1;
                res_if.ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
            end else begin
                mode    = $urandom_range(0, 3);
                span    = $urandom_range(8, 60);
                pattern = $urandom;
                for (int k = 0; k < span; k++) begin
                    case (mode)
                        0: res_if.ready <= 1'b1;
                        1: res_if.ready <= pattern[k % 32];
                        2: res_if.ready <= ($urandom_range(0, 3) != 0);
                        default: res_if.ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_fr_out want;
        t_fr_out got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.payload;
            if (pending_ratios.size() == 0) begin
                flag_mismatch($sformatf("unexpected result %h/%h",
                                        got.reduced_num, got.reduced_den));
            end else begin
                want = pending_ratios.pop_front();
                if (got.reduced_num !== want.reduced_num) begin
                    flag_mismatch($sformatf("reduced_num expected %h got %h",
                                            want.reduced_num, got.reduced_num));
                end
                if (got.reduced_den !== want.reduced_den) begin
                    flag_mismatch($sformatf("reduced_den expected %h got %h",
                                            want.reduced_den, got.reduced_den));
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("fraction_reducer test failed");
            $finish;
        end
    end

    initial idle_cycles = 0;

endmodule

[files.f]
rtl/core/fr_pkg.sv
rtl/core/fr_stream_if.sv
rtl/core/fr_datapath.sv
rtl/core/fr_controller.sv
rtl/core/fraction_reducer.sv
rtl/core/fr_checker.sv
test/fraction_reducer_tb.sv
